[design/ace_pkg.sv]
// ----------------------------------------------------------------------------
// ace_pkg: shared types and constants of the ARP cache engine
// Codes for commands, results, entry status and config registers, plus the
// flag bundle produced by the per-entry compare unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ace_pkg;

	localparam int DEF_ENTRIES = 16;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 32;
	localparam int IP_W      = 32;
	localparam int MAC_W     = 48;
	localparam int USE_W     = 16;
	localparam int TMR_W     = 8;
	localparam int CNT_W     = 4;
	localparam int ACT_W     = 3;
	localparam int OIDX_W    = 4;

	localparam logic [TMR_W-1:0] DEF_RETRY_TIMEOUT = 8'd5;
	localparam logic [CNT_W-1:0] DEF_MAX_RETRIES   = 4'd4;
	localparam logic [USE_W-1:0] DEF_USE_LIMIT     = 16'd255;

	// config register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MY_IP         = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RETRY_TIMEOUT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_RETRIES   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_USE_LIMIT     = 2'd3;

	// input commands
	localparam logic [1:0] CMD_SEND = 2'd0;
	localparam logic [1:0] CMD_RECV = 2'd1;
	localparam logic [1:0] CMD_TICK = 2'd2;
	localparam logic [1:0] CMD_NONE = 2'd3;

	// result actions
	localparam logic [ACT_W-1:0] ACT_TRANSMIT = 3'd0;
	localparam logic [ACT_W-1:0] ACT_HOLD     = 3'd1;
	localparam logic [ACT_W-1:0] ACT_REQUEST  = 3'd2;
	localparam logic [ACT_W-1:0] ACT_REPLY    = 3'd3;
	localparam logic [ACT_W-1:0] ACT_RELEASE  = 3'd4;
	localparam logic [ACT_W-1:0] ACT_DISCARD  = 3'd5;
	localparam logic [ACT_W-1:0] ACT_FULL     = 3'd6;

	// entry status
	localparam logic [1:0] ST_FREE    = 2'd0;
	localparam logic [1:0] ST_VALID   = 2'd1;
	localparam logic [1:0] ST_PENDING = 2'd2;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_SCAN  = 5'b00010,
		S_APPLY = 5'b00100,
		S_SCAN2 = 5'b01000,
		S_FLUSH = 5'b10000
	} state_t;

	// flags of one table entry against the current item
	typedef struct packed {
		logic is_free;
		logic is_pend;
		logic ip_hit;
		logic use_le;
		logic tmr_gt1;
		logic cnt_done;
	} cmp_t;

endpackage

`default_nettype wire

[design/arp_cache_engine_top.sv]
// ----------------------------------------------------------------------------
// arp_cache_engine_top: IP-to-MAC cache with least-used eviction
// Sequencer walking the table one entry per cycle (paused on output stalls)
// via a shared compare unit; emits action results through a registered output
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one command: send lookup,
//   received ARP packet or timer tick. in_stall is high while an item is
//   being worked on; the block takes one item at a time.
//   Output channel (out_valid/out_stall) carries result transfers; last
//   marks the final result of an item. A lookup gives one result, a tick
//   or a received reply may give none or several.
//   A lookup or received packet runs a table scan and an apply step; a
//   received reply adds a second scan to release pending entries, a tick
//   has the scan only. A scan visits one entry per cycle unless the output
//   stalls. Ignored packets and unknown commands start no scan.
//   When the receiver stalls, results wait in a one-deep hold stage and the
//   output register; the scan pauses until the output frees up.
//   Config writes (cfg_we) are registered and must be made while idle.
//   Reset clears all entries to free and loads default register values.
// ----------------------------------------------------------------------------
`default_nettype none

module arp_cache_engine_top #(
	parameter int TABLE_ENTRIES = ace_pkg::DEF_ENTRIES
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [ace_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ace_pkg::CFG_W-1:0]      cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [1:0]                     command,
	input  logic [ace_pkg::IP_W-1:0]       ip_addr,
	input  logic [ace_pkg::MAC_W-1:0]      mac_addr,
	input  logic [ace_pkg::IP_W-1:0]       target_ip,
	input  logic                           is_request,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [ace_pkg::ACT_W-1:0]      action,
	output logic [ace_pkg::OIDX_W-1:0]     entry_index,
	output logic [ace_pkg::IP_W-1:0]       peer_ip,
	output logic [ace_pkg::MAC_W-1:0]      peer_mac,
	output logic                           last
);
	import ace_pkg::*;

	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

	// config registers
	logic [IP_W-1:0]  my_ip_q;
	logic [TMR_W-1:0] retry_timeout_q;
	logic [CNT_W-1:0] max_retries_q;
	logic [USE_W-1:0] use_limit_q;

	// entry table
	logic [1:0]       st_q   [TABLE_ENTRIES];
	logic [IP_W-1:0]  eip_q  [TABLE_ENTRIES];
	logic [MAC_W-1:0] emac_q [TABLE_ENTRIES];
	logic [USE_W-1:0] use_q  [TABLE_ENTRIES];
	logic [TMR_W-1:0] tmr_q  [TABLE_ENTRIES];
	logic [CNT_W-1:0] cnt_q  [TABLE_ENTRIES];

	// sequencer and item
	state_t           state_q;
	logic [IDX_W-1:0] idx_q;
	logic [1:0]       cmd_q;
	logic [IP_W-1:0]  ip_q;
	logic [MAC_W-1:0] mac_q;
	logic             req_q;

	// scan trackers
	logic             hit_found_q, hit_pend_q, free_found_q, ev_found_q;
	logic [IDX_W-1:0] hit_idx_q, free_idx_q, ev_idx_q;
	logic [MAC_W-1:0] hit_mac_q;
	logic [USE_W-1:0] hit_use_q, minu_q;

	// hold stage and output register
	logic             hold_valid_q;
	logic [ACT_W-1:0] hold_act_q;
	logic [IDX_W-1:0] hold_idx_q;
	logic [IP_W-1:0]  hold_ip_q;
	logic [MAC_W-1:0] hold_mac_q;
	logic             out_valid_q, out_last_q;
	logic [ACT_W-1:0] out_act_q;
	logic [OIDX_W-1:0] out_idx_q;
	logic [IP_W-1:0]  out_ip_q;
	logic [MAC_W-1:0] out_mac_q;

	// entry under the pointer
	logic [1:0]       rd_st;
	logic [IP_W-1:0]  rd_ip;
	logic [MAC_W-1:0] rd_mac;
	logic [USE_W-1:0] rd_use;
	logic [TMR_W-1:0] rd_tmr;
	logic [CNT_W-1:0] rd_cnt;
	cmp_t             flags;

	// write and emit controls
	logic             st_we, ip_we, mac_we, use_we, tmr_we, cnt_we;
	logic [1:0]       st_wd;
	logic [MAC_W-1:0] mac_wd;
	logic [USE_W-1:0] use_wd;
	logic [TMR_W-1:0] tmr_wd;
	logic [CNT_W-1:0] cnt_wd;
	logic [IDX_W-1:0] wr_idx;
	logic             emit_now, step_go, slot_free, push_out, in_acc;
	logic [ACT_W-1:0] em_act;
	logic [IDX_W-1:0] em_idx;
	logic [IP_W-1:0]  em_ip;
	logic [MAC_W-1:0] em_mac;
	logic [IDX_W-1:0] alloc_idx;
	logic             alloc_ok;
	logic [USE_W:0]   use_inc;
	logic [IDX_W+OIDX_W-1:0] hold_idx_ext;

	assign rd_st  = st_q[idx_q];
	assign rd_ip  = eip_q[idx_q];
	assign rd_mac = emac_q[idx_q];
	assign rd_use = use_q[idx_q];
	assign rd_tmr = tmr_q[idx_q];
	assign rd_cnt = cnt_q[idx_q];

	ace_cmp_unit u_cmp (
		.status      (rd_st),
		.entry_ip    (rd_ip),
		.use_cnt     (rd_use),
		.timer       (rd_tmr),
		.retries     (rd_cnt),
		.key_ip      (ip_q),
		.min_use     (minu_q),
		.max_retries (max_retries_q),
		.flags       (flags)
	);

	assign in_stall  = (state_q != S_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign slot_free = !out_valid_q || !out_stall;

	// pick the allocation slot: first free, else eviction victim
	assign alloc_ok  = free_found_q || ev_found_q;
	assign alloc_idx = free_found_q ? free_idx_q : ev_idx_q;
	assign use_inc   = {1'b0, hit_use_q} + (USE_W+1)'(1);

	// decide table writes and emitted result for this cycle
	always_comb begin
		st_we = 1'b0; ip_we = 1'b0; mac_we = 1'b0;
		use_we = 1'b0; tmr_we = 1'b0; cnt_we = 1'b0;
		st_wd = ST_FREE; mac_wd = mac_q; use_wd = '0; tmr_wd = '0; cnt_wd = '0;
		wr_idx = idx_q;
		emit_now = 1'b0;
		em_act = ACT_TRANSMIT; em_idx = idx_q; em_ip = ip_q; em_mac = '0;
		unique case (state_q)
			S_SCAN: begin
				if (cmd_q == CMD_TICK && flags.is_pend) begin
					if (flags.tmr_gt1) begin
						tmr_we = 1'b1;
						tmr_wd = rd_tmr - TMR_W'(1);
					end else if (flags.cnt_done) begin
						st_we = 1'b1;
						st_wd = ST_FREE;
						emit_now = 1'b1;
						em_act = ACT_DISCARD;
						em_ip = rd_ip;
					end else begin
						cnt_we = 1'b1;
						cnt_wd = rd_cnt + CNT_W'(1);
						tmr_we = 1'b1;
						tmr_wd = retry_timeout_q;
						emit_now = 1'b1;
						em_act = ACT_REQUEST;
						em_ip = rd_ip;
					end
				end
			end
			S_APPLY: begin
				if (cmd_q == CMD_SEND) begin
					if (hit_found_q && !hit_pend_q) begin
						wr_idx = hit_idx_q;
						use_we = 1'b1;
						use_wd = (use_inc > {1'b0, use_limit_q}) ? use_limit_q
							: use_inc[USE_W-1:0];
						emit_now = 1'b1;
						em_act = ACT_TRANSMIT;
						em_idx = hit_idx_q;
						em_mac = hit_mac_q;
					end else if (hit_found_q) begin
						emit_now = 1'b1;
						em_act = ACT_HOLD;
						em_idx = hit_idx_q;
					end else if (alloc_ok) begin
						wr_idx = alloc_idx;
						st_we = 1'b1; st_wd = ST_PENDING;
						ip_we = 1'b1;
						mac_we = 1'b1; mac_wd = '0;
						use_we = 1'b1; use_wd = '0;
						tmr_we = 1'b1; tmr_wd = retry_timeout_q;
						cnt_we = 1'b1; cnt_wd = '0;
						emit_now = 1'b1;
						em_act = ACT_REQUEST;
						em_idx = alloc_idx;
					end else begin
						emit_now = 1'b1;
						em_act = ACT_FULL;
						em_idx = '0;
					end
				end else begin
					if (hit_found_q) begin
						wr_idx = hit_idx_q;
						mac_we = 1'b1;
						em_idx = hit_idx_q;
					end else if (free_found_q) begin
						wr_idx = free_idx_q;
						st_we = 1'b1; st_wd = ST_VALID;
						ip_we = 1'b1; mac_we = 1'b1;
						use_we = 1'b1; use_wd = '0;
						tmr_we = 1'b1; tmr_wd = '0;
						cnt_we = 1'b1; cnt_wd = '0;
						em_idx = free_idx_q;
					end else begin
						em_idx = '0;
					end
					emit_now = req_q;
					em_act = ACT_REPLY;
					em_mac = mac_q;
				end
			end
			S_SCAN2: begin
				if (flags.is_pend && flags.ip_hit) begin
					st_we = 1'b1;
					st_wd = ST_VALID;
					emit_now = 1'b1;
					em_act = ACT_RELEASE;
					em_ip = rd_ip;
					em_mac = rd_mac;
				end
			end
			S_IDLE, S_FLUSH: begin
			end
			default: begin
			end
		endcase
	end

	// pause the scan when a new result finds hold and output both busy
	assign step_go  = !(emit_now && hold_valid_q && !slot_free);
	assign push_out = hold_valid_q && slot_free &&
		((emit_now && step_go) || (state_q == S_FLUSH));

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			my_ip_q         <= '0;
			retry_timeout_q <= DEF_RETRY_TIMEOUT;
			max_retries_q   <= DEF_MAX_RETRIES;
			use_limit_q     <= DEF_USE_LIMIT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MY_IP:         my_ip_q         <= cfg_data[IP_W-1:0];
				REG_RETRY_TIMEOUT: retry_timeout_q <= cfg_data[TMR_W-1:0];
				REG_MAX_RETRIES:   max_retries_q   <= cfg_data[CNT_W-1:0];
				REG_USE_LIMIT:     use_limit_q     <= cfg_data[USE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// entry status, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TABLE_ENTRIES; i++) st_q[i] <= ST_FREE;
		end else if (st_we && step_go) begin
			st_q[wr_idx] <= st_wd;
		end
	end

	// entry payload fields
	always_ff @(posedge clk) begin
		if (step_go) begin
			if (ip_we)  eip_q[wr_idx]  <= ip_q;
			if (mac_we) emac_q[wr_idx] <= mac_wd;
			if (use_we) use_q[wr_idx]  <= use_wd;
			if (tmr_we) tmr_q[wr_idx]  <= tmr_wd;
			if (cnt_we) cnt_q[wr_idx]  <= cnt_wd;
		end
	end

	// latch the accepted item
	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_q <= command;
			ip_q  <= ip_addr;
			mac_q <= mac_addr;
			req_q <= is_request;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					idx_q <= '0;
					if (in_acc && command != CMD_NONE &&
						!(command == CMD_RECV && target_ip != my_ip_q)) begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (step_go) begin
						if (idx_q == LAST_IDX) begin
							idx_q   <= '0;
							state_q <= (cmd_q == CMD_TICK) ? S_FLUSH : S_APPLY;
						end else begin
							idx_q <= idx_q + IDX_W'(1);
						end
					end
				end
				S_APPLY: begin
					idx_q   <= '0;
					state_q <= (cmd_q == CMD_RECV && !req_q) ? S_SCAN2 : S_FLUSH;
				end
				S_SCAN2: begin
					if (step_go) begin
						if (idx_q == LAST_IDX) begin
							idx_q   <= '0;
							state_q <= S_FLUSH;
						end else begin
							idx_q <= idx_q + IDX_W'(1);
						end
					end
				end
				S_FLUSH: begin
					if (!hold_valid_q || slot_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// scan trackers: hit, first free, eviction candidate
	always_ff @(posedge clk) begin
		if (in_acc) begin
			hit_found_q  <= 1'b0;
			free_found_q <= 1'b0;
			ev_found_q   <= 1'b0;
			minu_q       <= use_limit_q;
		end else if (state_q == S_SCAN) begin
			if (flags.ip_hit && !flags.is_free && (cmd_q == CMD_SEND || !hit_found_q)) begin
				hit_found_q <= 1'b1;
				hit_idx_q   <= idx_q;
				hit_pend_q  <= flags.is_pend;
				hit_mac_q   <= rd_mac;
				hit_use_q   <= rd_use;
			end
			if (flags.is_free && !free_found_q) begin
				free_found_q <= 1'b1;
				free_idx_q   <= idx_q;
			end
			if (!flags.is_pend && flags.use_le) begin
				ev_found_q <= 1'b1;
				ev_idx_q   <= idx_q;
				minu_q     <= rd_use;
			end
		end
	end

	// hold stage: keeps one result until the next one shows whether it is last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_valid_q <= 1'b0;
		end else if (emit_now && step_go) begin
			hold_valid_q <= 1'b1;
		end else if (push_out) begin
			hold_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_now && step_go) begin
			hold_act_q <= em_act;
			hold_idx_q <= em_idx;
			hold_ip_q  <= em_ip;
			hold_mac_q <= em_mac;
		end
	end

	assign hold_idx_ext = {{OIDX_W{1'b0}}, hold_idx_q};

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push_out) begin
			out_act_q  <= hold_act_q;
			out_idx_q  <= hold_idx_ext[OIDX_W-1:0];
			out_ip_q   <= hold_ip_q;
			out_mac_q  <= hold_mac_q;
			out_last_q <= (state_q == S_FLUSH);
		end
	end

	assign out_valid   = out_valid_q;
	assign action      = out_act_q;
	assign entry_index = out_idx_q;
	assign peer_ip     = out_ip_q;
	assign peer_mac    = out_mac_q;
	assign last        = out_last_q;

`ifndef SYNTH
	// every result is handed on before the block takes a new item
	a_idle_hold_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !hold_valid_q)
		else $error("hold stage busy while idle");

	// lookups and received packets do not touch the table during the first scan
	a_scan_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && cmd_q != CMD_TICK) |-> !st_we && !tmr_we && !cnt_we)
		else $error("table written during lookup scan");

	// a stalled result is never overwritten
	a_out_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |-> !push_out)
		else $error("output overwritten under stall");

	// the flush step only leaves once the held result has gone out
	a_flush_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FLUSH && hold_valid_q && !slot_free) |=> (state_q == S_FLUSH))
		else $error("flush left with result still held");
`endif

endmodule

`default_nettype wire

[design/ace_cmp_unit.sv]
// ----------------------------------------------------------------------------
// ace_cmp_unit: shared compare unit
// Compares the table entry under the scan pointer with the current item and
// the running minimum; one entry is examined per cycle while the scan advances.
// ----------------------------------------------------------------------------
`default_nettype none

module ace_cmp_unit (
	input  logic [1:0]                 status,
	input  logic [ace_pkg::IP_W-1:0]   entry_ip,
	input  logic [ace_pkg::USE_W-1:0]  use_cnt,
	input  logic [ace_pkg::TMR_W-1:0]  timer,
	input  logic [ace_pkg::CNT_W-1:0]  retries,
	input  logic [ace_pkg::IP_W-1:0]   key_ip,
	input  logic [ace_pkg::USE_W-1:0]  min_use,
	input  logic [ace_pkg::CNT_W-1:0]  max_retries,
	output ace_pkg::cmp_t              flags
);
	import ace_pkg::*;

	// decode status and compare fields
	always_comb begin
		flags.is_free  = (status == ST_FREE);
		flags.is_pend  = (status == ST_PENDING);
		flags.ip_hit   = (entry_ip == key_ip);
		flags.use_le   = (use_cnt <= min_use);
		flags.tmr_gt1  = (timer > TMR_W'(1));
		flags.cnt_done = (retries >= max_retries);
	end

endmodule

`default_nettype wire
